### rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under reset
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication under reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/ehc_pkg.sv
`default_nettype none

package ehc_pkg;

    localparam int unsigned MAX_FRAME_BYTES = 65535;
    localparam int unsigned OFFSET_W = 16;

    localparam int unsigned ETH_HDR = 14;
    localparam int unsigned IPV4_HDR_END = 34;
    localparam int unsigned V6_HDR_END = 54;
    localparam int unsigned PORT_BYTES = 4;
    localparam int unsigned WIN_W = 7;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86DD;
    localparam logic [3:0] MIN_IHL = 4'd5;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [7:0] PROTO_ICMPV6 = 8'd58;

    localparam logic [4:0] NEED_TCP = 5'd20;
    localparam logic [4:0] NEED_UDP = 5'd8;
    localparam logic [4:0] NEED_ICMP = 5'd8;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_CAPTURE_ENABLE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_PER_SECOND = 1'b1;
    localparam logic [15:0] MAX_PER_SECOND_RESET = 16'd1000;

    localparam logic [5:0] SVC_NONE = 6'd0;
    localparam logic [5:0] SVC_UNKNOWN = 6'd1;
    localparam int unsigned SVC_ENTRIES = 34;

    localparam logic [15:0] SVC_PORT [SVC_ENTRIES] = '{
        16'd20, 16'd21, 16'd22, 16'd23, 16'd25, 16'd53, 16'd67, 16'd68, 16'd69,
        16'd80, 16'd110, 16'd119, 16'd123, 16'd143, 16'd161, 16'd194, 16'd443,
        16'd465, 16'd514, 16'd587, 16'd993, 16'd995, 16'd1080, 16'd1194,
        16'd1433, 16'd1521, 16'd3306, 16'd3389, 16'd5432, 16'd5900, 16'd6379,
        16'd8080, 16'd8443, 16'd27017
    };

    localparam logic [5:0] SVC_CODE [SVC_ENTRIES] = '{
        6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd8, 6'd9, 6'd10, 6'd11,
        6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21,
        6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31,
        6'd32, 6'd33, 6'd34
    };

    typedef enum logic [2:0] {
        ST_RECORDED,
        ST_CAPTURE_OFF,
        ST_TOO_SHORT,
        ST_NOT_IP,
        ST_BAD_IHL,
        ST_NO_TRANSPORT,
        ST_RATE_LIMITED
    } ehc_status_t;

    typedef enum logic [1:0] {
        CLS_TCP,
        CLS_UDP,
        CLS_ICMP,
        CLS_OTHER
    } ehc_class_t;

    typedef struct packed {
        logic       operation;
        logic [7:0] frame_byte;
        logic       last_byte;
    } ehc_req_t;

    typedef struct packed {
        ehc_status_t status;
        logic        ip_version;
        ehc_class_t  protocol_class;
        logic [16:0] packet_size;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic [5:0]  service_code;
        logic [63:0] source_address_high;
        logic [63:0] source_address_low;
        logic [63:0] destination_address_high;
        logic [63:0] destination_address_low;
    } ehc_rsp_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] byte_offset;
        logic [15:0]         ether_kind;
        logic [3:0]          header_length_words;
        logic [7:0]          next_protocol;
        logic [15:0]         length_field;
        logic [63:0]         src_high;
        logic [63:0]         src_low;
        logic [63:0]         dst_high;
        logic [63:0]         dst_low;
        logic [31:0]         port_pair;
    } ehc_frame_t;

    typedef struct packed {
        logic valid;
        logic tick;
    } ehc_snap_ctl_t;

    function automatic logic [5:0] ehc_service(input logic [15:0] port);
        logic [5:0] code;
        code = (port == 16'd0) ? SVC_NONE : SVC_UNKNOWN;
        for (int i = 0; i < SVC_ENTRIES; i++)
        begin
            if (port == SVC_PORT[i])
            begin
                code = SVC_CODE[i];
            end
        end
        return code;
    endfunction

endpackage

`default_nettype wire

### rtl/ehc_parser.sv
`default_nettype none

module ehc_parser
    import ehc_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire ehc_req_t      req,
    input  wire logic          snap_take,
    output ehc_snap_ctl_t      snap_ctl,
    output ehc_frame_t         snap
);

    ehc_frame_t    frame_reg;
    ehc_frame_t    frame_next;
    ehc_frame_t    frame_upd;
    ehc_frame_t    snap_reg;
    ehc_snap_ctl_t ctl_reg;
    ehc_snap_ctl_t ctl_next;

    logic                accept;
    logic [OFFSET_W-1:0] p;
    logic [7:0]          b;
    logic [WIN_W-1:0]    t;
    logic [OFFSET_W-1:0] t_wide;
    logic                port_win;

    assign req_ready = !ctl_reg.valid || snap_take;
    assign accept    = req_valid && req_ready;
    assign snap_ctl  = ctl_reg;
    assign snap      = snap_reg;

    assign p        = frame_reg.byte_offset;
    assign b        = req.frame_byte;
    assign t        = WIN_W'(ETH_HDR) + {1'b0, frame_reg.header_length_words, 2'b00};
    assign t_wide   = {{(OFFSET_W - WIN_W){1'b0}}, t};
    assign port_win = (p > OFFSET_W'(ETH_HDR)) && (frame_reg.header_length_words >= MIN_IHL)
                      && (p >= t_wide) && (p < t_wide + OFFSET_W'(PORT_BYTES));

    // byte capture at the current offset
    always_comb
    begin
        frame_upd = frame_reg;
        if (p != OFFSET_W'(MAX_FRAME_BYTES))
        begin
            frame_upd.byte_offset = p + 1'b1;
            if (p == 16'd12)
            begin
                frame_upd.ether_kind = {b, 8'h00};
            end
            else if (p == 16'd13)
            begin
                frame_upd.ether_kind = {frame_reg.ether_kind[15:8], b};
            end
            else if (frame_reg.ether_kind == ETHERTYPE_IPV4)
            begin
                if (p == 16'd14)
                begin
                    frame_upd.header_length_words = b[3:0];
                end
                else if (p == 16'd16)
                begin
                    frame_upd.length_field = {b, 8'h00};
                end
                else if (p == 16'd17)
                begin
                    frame_upd.length_field = {frame_reg.length_field[15:8], b};
                end
                else if (p == 16'd23)
                begin
                    frame_upd.next_protocol = b;
                end
                else if (p >= 16'd26 && p <= 16'd29)
                begin
                    frame_upd.src_low = {frame_reg.src_low[55:0], b};
                end
                else if (p >= 16'd30 && p <= 16'd33)
                begin
                    frame_upd.dst_low = {frame_reg.dst_low[55:0], b};
                end
                if (port_win)
                begin
                    frame_upd.port_pair = {frame_reg.port_pair[23:0], b};
                end
            end
            else if (frame_reg.ether_kind == ETHERTYPE_IPV6)
            begin
                if (p == 16'd18)
                begin
                    frame_upd.length_field = {b, 8'h00};
                end
                else if (p == 16'd19)
                begin
                    frame_upd.length_field = {frame_reg.length_field[15:8], b};
                end
                else if (p == 16'd20)
                begin
                    frame_upd.next_protocol = b;
                end
                else if (p >= 16'd22 && p <= 16'd29)
                begin
                    frame_upd.src_high = {frame_reg.src_high[55:0], b};
                end
                else if (p >= 16'd30 && p <= 16'd37)
                begin
                    frame_upd.src_low = {frame_reg.src_low[55:0], b};
                end
                else if (p >= 16'd38 && p <= 16'd45)
                begin
                    frame_upd.dst_high = {frame_reg.dst_high[55:0], b};
                end
                else if (p >= 16'd46 && p <= 16'd53)
                begin
                    frame_upd.dst_low = {frame_reg.dst_low[55:0], b};
                end
                else if (p >= OFFSET_W'(V6_HDR_END)
                         && p < OFFSET_W'(V6_HDR_END + PORT_BYTES))
                begin
                    frame_upd.port_pair = {frame_reg.port_pair[23:0], b};
                end
            end
        end
    end

    always_comb
    begin
        frame_next = frame_reg;
        ctl_next   = ctl_reg;
        if (snap_take)
        begin
            ctl_next = '0;
        end
        if (accept)
        begin
            if (req.operation == OP_TICK)
            begin
                ctl_next.valid = 1'b1;
                ctl_next.tick  = 1'b1;
            end
            else if (req.last_byte)
            begin
                frame_next     = '0;
                ctl_next.valid = 1'b1;
                ctl_next.tick  = 1'b0;
            end
            else
            begin
                frame_next = frame_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg <= '0;
            ctl_reg   <= '0;
        end
        else
        begin
            frame_reg <= frame_next;
            ctl_reg   <= ctl_next;
        end
    end

    // end-of-frame snapshot
    always_ff @(posedge clk)
    begin
        if (accept && req.operation == OP_BYTE && req.last_byte)
        begin
            snap_reg <= frame_upd;
        end
    end

endmodule

`default_nettype wire

### rtl/ehc_builder.sv
`default_nettype none

module ehc_builder
    import ehc_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          capture_enable,
    input  wire logic [15:0]   max_per_second,
    input  wire ehc_snap_ctl_t snap_ctl,
    input  wire ehc_frame_t    snap,
    output logic               snap_take,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output ehc_rsp_t           rsp
);

    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    ehc_rsp_t            rsp_reg;
    logic [15:0]         count_reg;
    logic [15:0]         count_next;

    logic [OFFSET_W-1:0] caplen;
    logic [WIN_W-1:0]    t;
    logic [OFFSET_W-1:0] t_wide;
    logic                v6;
    ehc_status_t         st;
    ehc_class_t          cls;
    logic [4:0]          need;
    logic [15:0]         sp;
    logic [15:0]         dp;
    logic [5:0]          svc_d;
    logic [5:0]          svc_s;
    logic [5:0]          svc;
    ehc_rsp_t            rec;
    logic                frame_take;

    assign snap_take  = snap_ctl.valid && (snap_ctl.tick || !rsp_valid_reg || rsp_ready);
    assign frame_take = snap_take && !snap_ctl.tick;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    assign caplen = snap.byte_offset;
    assign t_wide = {{(OFFSET_W - WIN_W){1'b0}}, t};

    always_comb
    begin
        t  = '0;
        v6 = 1'b0;
        st = ST_RECORDED;
        priority if (!capture_enable)
        begin
            st = ST_CAPTURE_OFF;
        end
        else if (caplen < OFFSET_W'(ETH_HDR))
        begin
            st = ST_TOO_SHORT;
        end
        else if (snap.ether_kind == ETHERTYPE_IPV4)
        begin
            t = WIN_W'(ETH_HDR) + {1'b0, snap.header_length_words, 2'b00};
            if (caplen < OFFSET_W'(IPV4_HDR_END))
            begin
                st = ST_TOO_SHORT;
            end
            else if (snap.header_length_words < MIN_IHL)
            begin
                st = ST_BAD_IHL;
            end
        end
        else if (snap.ether_kind == ETHERTYPE_IPV6)
        begin
            t  = WIN_W'(V6_HDR_END);
            v6 = 1'b1;
            if (caplen < OFFSET_W'(V6_HDR_END))
            begin
                st = ST_TOO_SHORT;
            end
        end
        else
        begin
            st = ST_NOT_IP;
        end
        if (st == ST_RECORDED && t_wide >= caplen)
        begin
            st = ST_NO_TRANSPORT;
        end
        if (st == ST_RECORDED && count_reg >= max_per_second)
        begin
            st = ST_RATE_LIMITED;
        end
    end

    always_comb
    begin
        unique case (snap.next_protocol)
            PROTO_TCP:
            begin
                cls  = CLS_TCP;
                need = NEED_TCP;
            end
            PROTO_UDP:
            begin
                cls  = CLS_UDP;
                need = NEED_UDP;
            end
            PROTO_ICMP, PROTO_ICMPV6:
            begin
                cls  = CLS_ICMP;
                need = NEED_ICMP;
            end
            default:
            begin
                cls  = CLS_OTHER;
                need = '0;
            end
        endcase
    end

    always_comb
    begin
        sp = '0;
        dp = '0;
        if (cls != CLS_OTHER && t_wide + {11'b0, need} <= caplen)
        begin
            if (cls == CLS_ICMP)
            begin
                sp = {8'h00, snap.port_pair[31:24]};
                dp = {8'h00, snap.port_pair[23:16]};
            end
            else
            begin
                sp = snap.port_pair[31:16];
                dp = snap.port_pair[15:0];
            end
        end
        svc_d = ehc_service(dp);
        svc_s = ehc_service(sp);
        if (cls == CLS_ICMP)
        begin
            svc = SVC_NONE;
        end
        else if (svc_d <= SVC_UNKNOWN)
        begin
            svc = svc_s;
        end
        else
        begin
            svc = svc_d;
        end
    end

    always_comb
    begin
        rec        = '0;
        rec.status = st;
        if (st == ST_RECORDED)
        begin
            rec.ip_version       = v6;
            rec.protocol_class   = cls;
            rec.packet_size      = v6 ? {1'b0, snap.length_field} + 17'd40
                                      : {1'b0, snap.length_field};
            rec.source_port      = sp;
            rec.destination_port = dp;
            rec.service_code     = svc;
            rec.source_address_high      = v6 ? snap.src_high : '0;
            rec.source_address_low       = v6 ? snap.src_low : {32'h0, snap.src_low[31:0]};
            rec.destination_address_high = v6 ? snap.dst_high : '0;
            rec.destination_address_low  = v6 ? snap.dst_low : {32'h0, snap.dst_low[31:0]};
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (snap_take)
        begin
            if (snap_ctl.tick)
            begin
                count_next = '0;
            end
            else
            begin
                rsp_valid_next = 1'b1;
                if (st == ST_RECORDED)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_take)
        begin
            rsp_reg <= rec;
        end
    end

endmodule

`default_nettype wire

### rtl/ethernet_ip_header_classifier.sv
// Ethernet/IP header classifier.
// Request channel (req_valid/req_ready/req): one captured frame byte per
// request, with last_byte on the final byte, or a one-second tick that
// clears the per-second frame counter.
// Result channel (rsp_valid/rsp_ready/rsp): one record per frame, issued
// for the request carrying last_byte; ticks and other bytes give none.
// Configuration: cfg_we writes cfg_data to register cfg_index
// (0 capture enable, 1 frames per second limit) with no handshake.
// Throughput: one request per clock while req_ready is high, set by the
// byte parser's single pass over each byte.
// Pipeline: once its last byte is accepted, the header capture is held in
// the frame snapshot, then classification and service table lookup write
// the record into the result register.
// Stall: while rsp_ready is low the record holds, one more frame end waits
// in the snapshot and req_ready drops only when both are full; ticks and
// mid-frame bytes still flow behind a waiting snapshot slot once it frees.
// Reset: asynchronous, clears the frame state, counter and valids; capture
// is off and the limit is 1000 frames per second.
`default_nettype none

module ethernet_ip_header_classifier
    import ehc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   req_valid,
    output logic                        req_ready,
    input  wire ehc_req_t               req,
    output logic                        rsp_valid,
    input  wire logic                   rsp_ready,
    output ehc_rsp_t                    rsp,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    logic          capture_enable_reg;
    logic [15:0]   max_per_second_reg;
    ehc_snap_ctl_t snap_ctl;
    ehc_frame_t    snap;
    logic          snap_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capture_enable_reg <= 1'b0;
            max_per_second_reg <= MAX_PER_SECOND_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CAPTURE_ENABLE: capture_enable_reg <= cfg_data[0];
                REG_MAX_PER_SECOND: max_per_second_reg <= cfg_data[15:0];
            endcase
        end
    end

    ehc_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .snap_take (snap_take),
        .snap_ctl  (snap_ctl),
        .snap      (snap)
    );

    ehc_builder u_builder (
        .clk            (clk),
        .rst_n          (rst_n),
        .capture_enable (capture_enable_reg),
        .max_per_second (max_per_second_reg),
        .snap_ctl       (snap_ctl),
        .snap           (snap),
        .snap_take      (snap_take),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .rsp            (rsp)
    );

endmodule

`default_nettype wire

### rtl/ehc_checker.sv
`default_nettype none
`include "assert_macros.svh"

module ehc_checker
    import ehc_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     rsp_valid,
    input wire logic     rsp_ready,
    input wire ehc_rsp_t rsp
);

    // record holds while stalled
    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

    // anything but a recorded frame carries only its status
    `ASSERT_IMPLIES(a_reject_zero, clk, rst_n, rsp_valid && rsp.status != ST_RECORDED, rsp.ip_version == 1'b0 && rsp.packet_size == '0 && rsp.source_port == '0 && rsp.destination_port == '0 && rsp.service_code == '0 && rsp.source_address_low == '0 && rsp.destination_address_low == '0)

    // icmp never gets a service
    `ASSERT_IMPLIES(a_icmp_svc, clk, rst_n, rsp_valid && rsp.protocol_class == CLS_ICMP, rsp.service_code == SVC_NONE)

    // ipv4 addresses sit in the low 32 bits
    `ASSERT_IMPLIES(a_v4_addr, clk, rst_n, rsp_valid && rsp.status == ST_RECORDED && !rsp.ip_version, rsp.source_address_high == '0 && rsp.destination_address_high == '0 && rsp.source_address_low[63:32] == '0 && rsp.destination_address_low[63:32] == '0)

endmodule

bind ethernet_ip_header_classifier ehc_checker u_ehc_checker (.*);

`default_nettype wire
